/* rtl/gbn_pkg.sv */
package gbn_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSG,
      ST_ACK,
      ST_TICK,
      ST_FILL,
      ST_RD,
      ST_WAIT,
      ST_DROP
   } state_type;

   localparam logic [1:0] OP_MSG  = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_WINDOW  = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30;
   localparam logic [3:0]  WINDOW_RESET  = 4'd8;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [63:0]        payload;
      logic [15:0]        in_seq;
      logic [15:0]        in_ack;
      logic signed [31:0] in_checksum;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        pkt_seq;
      logic [15:0]        pkt_ack;
      logic signed [31:0] pkt_checksum;
      logic [63:0]        pkt_payload;
      logic               last;
   } rsp_type;

   // Sum of the payload bytes, each taken as a signed byte, wrapping at 32 bits.
   function automatic logic [31:0] byte_sum(logic [63:0] p);
      logic [31:0] s;
      logic [7:0]  b;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         b = p[8*i +: 8];
         s = s + {{24{b[7]}}, b};
      end
      return s;
   endfunction

endpackage

/* rtl/gbn_pkt_buf.sv */
module gbn_pkt_buf #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/go_back_n_sender_unit.sv */
// Go-Back-N sender.
// req channel (valid/ready): opcode 0 queues a message payload, opcode 1 delivers an
// acknowledgement, opcode 2 is one retransmit-timer tick; opcode 3 is consumed silently.
// rsp channel (valid/ready): sent data packets, or a drop notice when the packet buffer
// is full; last marks the final result caused by one request.
// csr port: index 0 timeout_ticks, index 1 window limit; write only while idle.
// Sequence: a message passes ST_MSG, then ST_FILL, or ST_DROP when the buffer is full; an
// ack passes ST_ACK, then ST_FILL if accepted; a tick passes ST_TICK, then ST_RD on a
// timeout. Opcode 3 does not leave idle. Each packet sent takes ST_RD (buffer read), then
// ST_WAIT (output load), as the packet buffer's read is registered. A burst holds at most
// WINDOW_MAX packets.
// req_ready is high whenever the sequencer is idle, even if a result still waits in
// the output register. When the receiver stalls, the sequencer holds with the next
// packet in its read register until the output register frees up.
// Reset: base, next and tail sequence numbers go to 1, timer stops, timeout 30,
// window 8. The packet buffer is not cleared; only written entries are ever read.
module go_back_n_sender_unit #(
   parameter int WINDOW_MAX    = 8,
   parameter int BUF_DEPTH     = 64,
   parameter int PAYLOAD_BYTES = 8,
   parameter int SEQ_BITS      = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gbn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output gbn_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);

   localparam int     SLOT_W   = $clog2(BUF_DEPTH);
   localparam int     CNT_W    = $clog2(WINDOW_MAX + 1);
   localparam int     PAY_W    = 8 * PAYLOAD_BYTES;
   localparam longint SEQ_MASK = (64'd1 << SEQ_BITS) - 64'd1;
   localparam int     BUF_CAP  = (longint'(BUF_DEPTH) < SEQ_MASK) ? BUF_DEPTH
                                                                  : int'(SEQ_MASK);

   function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                  logic [SLOT_W:0] b);
      logic [SLOT_W:0] s;
      s = {1'b0, a} + b;
      if (s >= (SLOT_W+1)'(BUF_DEPTH)) begin
         s = s - (SLOT_W+1)'(BUF_DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

   gbn_pkg::state_type state_ff, state_in;

   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [SEQ_BITS-1:0] nts_ff, nts_in;
   logic [SEQ_BITS-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0]   bslot_ff, bslot_in;
   logic                timer_run_ff, timer_run_in;
   logic [15:0]         timer_cnt_ff, timer_cnt_in;
   logic [15:0]         timeout_ff, timeout_in;
   logic [3:0]          wsize_ff, wsize_in;
   logic [CNT_W-1:0]    burst_off_ff, burst_off_in;
   logic [CNT_W-1:0]    burst_cnt_ff, burst_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [1:0]          op_ff, op_in;
   logic [PAY_W-1:0]    pay_ff, pay_in;
   logic [15:0]         iseq_ff, iseq_in;
   logic [15:0]         iack_ff, iack_in;
   logic [31:0]         ichk_ff, ichk_in;
   logic [SEQ_BITS-1:0] rd_seq_ff, rd_seq_in;
   logic                rd_last_ff, rd_last_in;
   gbn_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                mem_we, mem_re;
   logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
   logic [PAY_W-1:0]    mem_rdata;

   logic                req_fire, out_free;
   logic [SEQ_BITS-1:0] win0, win1, win_eff;
   logic [SEQ_BITS-1:0] occ, noff, rem, avail, cnt_full;
   logic                buf_full;
   logic [SEQ_BITS-1:0] ack_num, ack_dist, ack_k, base_new;
   logic [31:0]         ack_sum;
   logic                ack_ok;
   logic [15:0]         tick_limit;
   logic                tick_fire;
   logic [CNT_W-1:0]    fill_cnt, resend_cnt;

   assign req_ready = (state_ff == gbn_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // effective window: zero acts as one, clamp to WINDOW_MAX and buffer capacity
   assign win0    = (wsize_ff == 4'd0) ? SEQ_BITS'(1) : SEQ_BITS'(wsize_ff);
   assign win1    = (win0 > SEQ_BITS'(WINDOW_MAX)) ? SEQ_BITS'(WINDOW_MAX) : win0;
   assign win_eff = (win1 > SEQ_BITS'(BUF_CAP)) ? SEQ_BITS'(BUF_CAP) : win1;

   assign occ      = tail_ff - base_ff;
   assign noff     = nts_ff - base_ff;
   assign rem      = tail_ff - nts_ff;
   assign buf_full = (occ >= SEQ_BITS'(BUF_CAP));

   assign avail    = (noff < win_eff) ? (win_eff - noff) : '0;
   assign cnt_full = (avail < rem) ? avail : rem;
   assign fill_cnt = (op_ff == gbn_pkg::OP_MSG && cnt_full > SEQ_BITS'(1))
                     ? CNT_W'(1) : CNT_W'(cnt_full);
   assign resend_cnt = (noff > SEQ_BITS'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(noff);

   assign ack_sum  = 32'(iseq_ff) + 32'(iack_ff) + gbn_pkg::byte_sum(64'(pay_ff));
   assign ack_num  = SEQ_BITS'(iack_ff);
   assign ack_dist = ack_num - base_ff;
   assign ack_k    = ack_dist + SEQ_BITS'(1);
   assign base_new = ack_num + SEQ_BITS'(1);
   assign ack_ok   = (ack_sum == ichk_ff) && (ack_dist < occ);

   assign tick_limit = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign tick_fire  = ({1'b0, timer_cnt_ff} + 17'd1) >= {1'b0, tick_limit};

   gbn_pkt_buf #(
      .DEPTH  (BUF_DEPTH),
      .DATA_W (PAY_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (pay_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode)
                  gbn_pkg::OP_MSG:  state_in = gbn_pkg::ST_MSG;
                  gbn_pkg::OP_ACK:  state_in = gbn_pkg::ST_ACK;
                  gbn_pkg::OP_TICK: state_in = gbn_pkg::ST_TICK;
                  default:          state_in = gbn_pkg::ST_IDLE;
               endcase
            end
         end
         gbn_pkg::ST_MSG:  state_in = buf_full ? gbn_pkg::ST_DROP : gbn_pkg::ST_FILL;
         gbn_pkg::ST_ACK:  state_in = ack_ok ? gbn_pkg::ST_FILL : gbn_pkg::ST_IDLE;
         gbn_pkg::ST_TICK: begin
            state_in = (timer_run_ff && tick_fire && resend_cnt != '0)
                       ? gbn_pkg::ST_RD : gbn_pkg::ST_IDLE;
         end
         gbn_pkg::ST_FILL: state_in = (fill_cnt != '0) ? gbn_pkg::ST_RD : gbn_pkg::ST_IDLE;
         gbn_pkg::ST_RD:   state_in = gbn_pkg::ST_WAIT;
         gbn_pkg::ST_WAIT: begin
            if (out_free) begin
               state_in = (burst_cnt_ff != '0) ? gbn_pkg::ST_RD : gbn_pkg::ST_IDLE;
            end
         end
         gbn_pkg::ST_DROP: begin
            if (out_free) begin
               state_in = gbn_pkg::ST_IDLE;
            end
         end
         default: state_in = gbn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      base_in      = base_ff;
      nts_in       = nts_ff;
      tail_in      = tail_ff;
      bslot_in     = bslot_ff;
      timer_run_in = timer_run_ff;
      timer_cnt_in = timer_cnt_ff;
      timeout_in   = timeout_ff;
      wsize_in     = wsize_ff;
      burst_off_in = burst_off_ff;
      burst_cnt_in = burst_cnt_ff;
      op_in        = op_ff;
      pay_in       = pay_ff;
      iseq_in      = iseq_ff;
      iack_in      = iack_ff;
      ichk_in      = ichk_ff;
      rd_seq_in    = rd_seq_ff;
      rd_last_in   = rd_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = slot_add(bslot_ff, (SLOT_W+1)'(occ));
      mem_re       = 1'b0;
      mem_raddr    = slot_add(bslot_ff, (SLOT_W+1)'(burst_off_ff));

      if (csr_we) begin
         unique case (csr_index)
            gbn_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            gbn_pkg::CSR_WINDOW:  wsize_in   = csr_wdata[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_data.opcode;
               pay_in  = PAY_W'(req_data.payload);
               iseq_in = req_data.in_seq;
               iack_in = req_data.in_ack;
               ichk_in = req_data.in_checksum;
            end
         end
         gbn_pkg::ST_MSG: begin
            if (!buf_full) begin
               mem_we  = 1'b1;
               tail_in = tail_ff + SEQ_BITS'(1);
            end
         end
         gbn_pkg::ST_ACK: begin
            if (ack_ok) begin
               base_in  = base_new;
               bslot_in = slot_add(bslot_ff, (SLOT_W+1)'(ack_k));
               // next_to_send never falls behind the new base
               if (noff < ack_k) begin
                  nts_in = base_new;
               end
            end
         end
         gbn_pkg::ST_TICK: begin
            if (timer_run_ff) begin
               if (tick_fire) begin
                  timer_cnt_in = '0;
                  burst_off_in = '0;
                  burst_cnt_in = resend_cnt;
               end else begin
                  timer_cnt_in = timer_cnt_ff + 16'd1;
               end
            end
         end
         gbn_pkg::ST_FILL: begin
            nts_in       = nts_ff + SEQ_BITS'(fill_cnt);
            burst_off_in = CNT_W'(noff);
            burst_cnt_in = fill_cnt;
            if (op_ff == gbn_pkg::OP_MSG) begin
               // start the timer when the window's first packet goes out
               if (fill_cnt != '0 && nts_ff == base_ff) begin
                  timer_run_in = 1'b1;
                  timer_cnt_in = '0;
               end
            end else begin
               timer_cnt_in = '0;
               timer_run_in = (fill_cnt != '0) || (nts_ff != base_ff);
            end
         end
         gbn_pkg::ST_RD: begin
            mem_re       = 1'b1;
            rd_seq_in    = base_ff + SEQ_BITS'(burst_off_ff);
            rd_last_in   = (burst_cnt_ff == CNT_W'(1));
            burst_off_in = burst_off_ff + CNT_W'(1);
            burst_cnt_in = burst_cnt_ff - CNT_W'(1);
         end
         gbn_pkg::ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.kind          = gbn_pkg::KIND_DATA;
               rsp_data_in.pkt_seq       = 16'(rd_seq_ff);
               rsp_data_in.pkt_ack       = '0;
               rsp_data_in.pkt_checksum  = 32'(rd_seq_ff) + gbn_pkg::byte_sum(64'(mem_rdata));
               rsp_data_in.pkt_payload   = 64'(mem_rdata);
               rsp_data_in.last          = rd_last_ff;
            end
         end
         gbn_pkg::ST_DROP: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.kind          = gbn_pkg::KIND_DROP;
               rsp_data_in.pkt_seq       = '0;
               rsp_data_in.pkt_ack       = '0;
               rsp_data_in.pkt_checksum  = '0;
               rsp_data_in.pkt_payload   = '0;
               rsp_data_in.last          = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbn_pkg::ST_IDLE;
         base_ff      <= SEQ_BITS'(1);
         nts_ff       <= SEQ_BITS'(1);
         tail_ff      <= SEQ_BITS'(1);
         bslot_ff     <= '0;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
         timeout_ff   <= gbn_pkg::TIMEOUT_RESET;
         wsize_ff     <= gbn_pkg::WINDOW_RESET;
         burst_off_ff <= '0;
         burst_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         nts_ff       <= nts_in;
         tail_ff      <= tail_in;
         bslot_ff     <= bslot_in;
         timer_run_ff <= timer_run_in;
         timer_cnt_ff <= timer_cnt_in;
         timeout_ff   <= timeout_in;
         wsize_ff     <= wsize_in;
         burst_off_ff <= burst_off_in;
         burst_cnt_ff <= burst_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pay_ff      <= pay_in;
      iseq_ff     <= iseq_in;
      iack_ff     <= iack_in;
      ichk_ff     <= ichk_in;
      rd_seq_ff   <= rd_seq_in;
      rd_last_ff  <= rd_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      occ <= SEQ_BITS'(BUF_CAP))
      else $error("buffer occupancy above capacity");

   a_nts_range: assert property (@(posedge clock) disable iff (reset)
      noff <= occ)
      else $error("next_to_send outside [base, tail]");

   a_idle_burst: assert property (@(posedge clock) disable iff (reset)
      state_ff == gbn_pkg::ST_IDLE |-> burst_cnt_ff == '0)
      else $error("burst left unfinished at idle");

   a_timer_outstanding: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbn_pkg::ST_IDLE && timer_run_ff) |-> nts_ff != base_ff)
      else $error("timer running with nothing outstanding");

   a_rd_then_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == gbn_pkg::ST_RD |=> state_ff == gbn_pkg::ST_WAIT)
      else $error("buffer read not followed by output load");

endmodule
